// ----- design/gasa_pkg.sv -----
// Shared types and constants for the glyph atlas shelf allocator.
`timescale 1ns / 1ps
`default_nettype none

package gasa_pkg;

    // Field widths
    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int HEIGHT_W   = 9;
    localparam int WIDTH_W    = 11;
    localparam int COL_W      = 11;
    localparam int ORIGIN_X_W = 10;
    localparam int ORIGIN_Y_W = 8;
    localparam int PCT_W      = 7;
    localparam int PCT_SCALE  = 100;

    typedef logic [HEIGHT_W-1:0] t_height;

    // Shelf heights after reset
    localparam t_height HEIGHT_RST [NUM_REGS] = '{
        9'd16, 9'd24, 9'd24, 9'd32, 9'd32, 9'd40, 9'd88
    };

    typedef enum logic {
        ACT_PLACE = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_PLACED     = 2'd0,
        ST_TOO_TALL   = 2'd1,
        ST_NO_ROOM    = 2'd2,
        ST_FLUSH_DONE = 2'd3
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [WIDTH_W-1:0]  glyph_width;
        logic [HEIGHT_W-1:0] glyph_height;
    } t_glyph_req;

    typedef struct packed {
        t_status               status;
        logic [ORIGIN_X_W-1:0] origin_x;
        logic [ORIGIN_Y_W-1:0] origin_y;
        logic                  flushed;
        logic [PCT_W-1:0]      free_percent;
    } t_glyph_rsp;

endpackage

`default_nettype wire

// ----- design/gasa_pct_div.sv -----
// Free-width percentage unit: one multiply by the scaled reciprocal of the shelf total.
`timescale 1ns / 1ps
`default_nettype none

module gasa_pct_div #(
    parameter int NUM_SHELVES = 7,
    parameter int ATLAS_WIDTH = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic [$clog2(NUM_SHELVES*ATLAS_WIDTH+1)-1:0] i_remaining,
    output logic                                         o_done,
    output logic [gasa_pkg::PCT_W-1:0]                   o_percent
);

    localparam int REM_W   = $clog2(NUM_SHELVES*ATLAS_WIDTH+1);
    localparam int QUOT_W  = gasa_pkg::PCT_W;
    localparam int NUM_W   = REM_W + QUOT_W;
    localparam int TOTAL   = NUM_SHELVES * ATLAS_WIDTH;
    // Shift wide enough that the rounded-up reciprocal is exact for every numerator
    localparam int SHIFT   = NUM_W + $clog2(TOTAL);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
    localparam longint unsigned SCALED_RECIP = RECIP * 64'(gasa_pkg::PCT_SCALE);
    localparam int K_W     = $clog2(SCALED_RECIP + 64'd1);
    localparam int PROD_W  = (REM_W + K_W > SHIFT + QUOT_W) ? REM_W + K_W : SHIFT + QUOT_W;

    logic [QUOT_W-1:0] r_q;
    logic              r_done;

    logic [PROD_W-1:0] w_prod;

    // Remaining width times 100 over the total, as one constant multiply
    assign w_prod = PROD_W'(i_remaining) * PROD_W'(SCALED_RECIP);

    // Result is ready in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_prod[SHIFT +: QUOT_W];
        end
    end

    assign o_done    = r_done;
    assign o_percent = r_q;

endmodule

`default_nettype wire

// ----- design/glyph_atlas_shelf_allocator_unit.sv -----
// Glyph atlas shelf allocator: sequencer, shelf state and response register.
//
// Requests arrive on the i_req valid/ready channel: a place carries a glyph
// width and height, a flush clears every shelf column. Each request gives
// exactly one response transaction on the o_rsp valid/ready channel with the
// status, placed origin, a flushed flag and the free shelf width in percent.
// Shelf heights are written through the i_cfg channel (always ready); the
// user must write them only while the block is idle, which the block does
// not enforce. Indexes beyond the last height register are ignored.
//
// One request is worked at a time and o_req_ready is low meanwhile. The
// shelf search walks one shelf per cycle (twice when it has to clear and
// retry), the free-width sum walks one shelf per cycle, and the percentage
// is one reciprocal multiply. o_req_ready returns in the same cycle that
// the response turns valid.
// The response sits in an output register; while the receiver stalls, the
// finished result waits there and the next request may already be taken,
// but its own response waits until the register frees up.
// Reset clears all shelf columns, loads the default shelf heights and
// drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module glyph_atlas_shelf_allocator_unit #(
    parameter int NUM_SHELVES = 7,
    parameter int ATLAS_WIDTH = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire gasa_pkg::t_glyph_req              i_req,
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output gasa_pkg::t_glyph_rsp                   o_rsp,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gasa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gasa_pkg::HEIGHT_W-1:0]     i_cfg_data
);

    localparam int IDX_W      = (NUM_SHELVES > 1) ? $clog2(NUM_SHELVES) : 1;
    localparam int COL_W      = gasa_pkg::COL_W;
    localparam int AW_W       = $clog2(ATLAS_WIDTH + 1);
    localparam int CMP_W      = (AW_W > COL_W + 1) ? AW_W : COL_W + 1;
    localparam int REM_W      = $clog2(NUM_SHELVES*ATLAS_WIDTH + 1);
    localparam int LAST_SHELF = NUM_SHELVES - 1;
    localparam int NUM_REGS   = gasa_pkg::NUM_REGS;
    localparam logic [CMP_W-1:0] AW_C = CMP_W'(ATLAS_WIDTH);
    localparam logic [gasa_pkg::CFG_IDX_W-1:0] LAST_REG =
        (LAST_SHELF < NUM_REGS) ? gasa_pkg::CFG_IDX_W'(LAST_SHELF) : '0;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SUM    = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    // Registers
    t_state                              r_state, n_state;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic [gasa_pkg::ORIGIN_Y_W-1:0]     r_row, n_row;
    logic                                r_retry, n_retry;
    logic [gasa_pkg::WIDTH_W-1:0]        r_w, n_w;
    logic [gasa_pkg::HEIGHT_W-1:0]       r_h, n_h;
    gasa_pkg::t_status                   r_status, n_status;
    logic [gasa_pkg::ORIGIN_X_W-1:0]     r_ox, n_ox;
    logic [gasa_pkg::ORIGIN_Y_W-1:0]     r_oy, n_oy;
    logic                                r_flushed, n_flushed;
    logic [REM_W-1:0]                    r_rem, n_rem;
    logic                                r_start, n_start;
    logic [COL_W-1:0]                    r_col [NUM_SHELVES];
    gasa_pkg::t_height                   r_height [NUM_REGS];
    logic                                r_rsp_valid;
    gasa_pkg::t_glyph_rsp                r_rsp;

    // Combinational helpers
    logic [3:0]                          w_idx_ext;
    gasa_pkg::t_height                   w_sh;
    gasa_pkg::t_height                   w_last_h;
    logic [COL_W-1:0]                    w_col;
    logic [CMP_W-1:0]                    w_col_x;
    logic [CMP_W-1:0]                    w_sum;
    logic [CMP_W-1:0]                    w_term;
    logic                                w_fit;
    logic                                w_last;
    logic                                w_clear;
    logic                                w_place;
    logic                                w_slot_free;
    logic                                w_div_done;
    logic [gasa_pkg::PCT_W-1:0]          w_percent;

    // Shelf lookups at the walking index
    assign w_idx_ext = 4'(r_idx);
    assign w_sh      = (w_idx_ext < 4'(NUM_REGS)) ? r_height[w_idx_ext[2:0]] : '0;
    assign w_last_h  = (LAST_SHELF < NUM_REGS) ? r_height[LAST_REG] : '0;
    assign w_col     = r_col[r_idx];
    assign w_col_x   = CMP_W'(w_col);
    assign w_sum     = w_col_x + CMP_W'(r_w);
    assign w_fit     = (r_h <= w_sh) && (w_sum < AW_C);
    assign w_term    = (w_col_x < AW_C) ? (AW_C - w_col_x) : '0;
    assign w_last    = (r_idx == IDX_W'(LAST_SHELF));
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_row     = r_row;
        n_retry   = r_retry;
        n_w       = r_w;
        n_h       = r_h;
        n_status  = r_status;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_flushed = r_flushed;
        n_rem     = r_rem;
        n_start   = 1'b0;
        w_clear   = 1'b0;
        w_place   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_w       = i_req.glyph_width;
                    n_h       = i_req.glyph_height;
                    n_idx     = '0;
                    n_row     = '0;
                    n_retry   = 1'b0;
                    n_ox      = '0;
                    n_oy      = '0;
                    n_rem     = '0;
                    n_flushed = 1'b0;
                    if (i_req.action == gasa_pkg::ACT_FLUSH) begin
                        w_clear   = 1'b1;
                        n_flushed = 1'b1;
                        n_status  = gasa_pkg::ST_FLUSH_DONE;
                        n_state   = S_SUM;
                    end else if (i_req.glyph_height > w_last_h) begin
                        n_status = gasa_pkg::ST_TOO_TALL;
                        n_state  = S_SUM;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_fit) begin
                    w_place  = 1'b1;
                    n_ox     = w_col[gasa_pkg::ORIGIN_X_W-1:0];
                    n_oy     = r_row;
                    n_status = gasa_pkg::ST_PLACED;
                    n_idx    = '0;
                    n_state  = S_SUM;
                end else if (w_last) begin
                    n_idx = '0;
                    n_row = '0;
                    if (r_retry) begin
                        n_status = gasa_pkg::ST_NO_ROOM;
                        n_state  = S_SUM;
                    end else begin
                        // Nothing fits: clear all shelves and search again
                        w_clear   = 1'b1;
                        n_flushed = 1'b1;
                        n_retry   = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                    n_row = r_row + w_sh[gasa_pkg::ORIGIN_Y_W-1:0];
                end
            end
            S_SUM: begin
                n_rem = r_rem + REM_W'(w_term);
                if (w_last) begin
                    n_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_row     <= n_row;
        r_retry   <= n_retry;
        r_w       <= n_w;
        r_h       <= n_h;
        r_status  <= n_status;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_flushed <= n_flushed;
        r_rem     <= n_rem;
    end

    // Shelf fill columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int i = 0; i < NUM_SHELVES; i++) begin
                r_col[i] <= '0;
            end
        end else if (w_place) begin
            r_col[r_idx] <= w_sum[COL_W-1:0];
        end
    end

    // Shelf height registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_height[i] <= gasa_pkg::HEIGHT_RST[i];
            end
        end else if (i_cfg_valid &&
                     (i_cfg_index < gasa_pkg::CFG_IDX_W'(NUM_REGS))) begin
            r_height[i_cfg_index] <= i_cfg_data;
        end
    end

    // Percentage unit
    gasa_pct_div #(
        .NUM_SHELVES (NUM_SHELVES),
        .ATLAS_WIDTH (ATLAS_WIDTH)
    ) u_pct_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_remaining (r_rem),
        .o_done      (w_div_done),
        .o_percent   (w_percent)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_slot_free) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_slot_free) begin
            r_rsp.status       <= r_status;
            r_rsp.origin_x     <= r_ox;
            r_rsp.origin_y     <= r_oy;
            r_rsp.flushed      <= r_flushed;
            r_rsp.free_percent <= w_percent;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
